// ===== sv/rdh_pkg.sv =====
// ----------------------------------------------------------------------------
// rdh_pkg
// Shared types, codes and sizes for the reuse distance histogram block.
// ----------------------------------------------------------------------------
package rdh_pkg;

	localparam int MAX_WINDOW_DEF = 256;
	localparam int NBINS          = 256;
	localparam int BIN_W          = 8;
	localparam int ADDR_W         = 64;
	localparam int CNT_W          = 64;
	localparam int LEN_W          = 9;

	localparam logic [1:0] OP_ACCESS = 2'd0;
	localparam logic [1:0] OP_BIN    = 2'd1;
	localparam logic [1:0] OP_MEDIAN = 2'd2;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_DISP   = 4'd2;
	localparam logic [3:0] ST_SCAN   = 4'd3;
	localparam logic [3:0] ST_COUNT  = 4'd4;
	localparam logic [3:0] ST_HIST   = 4'd5;
	localparam logic [3:0] ST_HWRITE = 4'd6;
	localparam logic [3:0] ST_SLOT   = 4'd7;
	localparam logic [3:0] ST_PRUNE  = 4'd8;
	localparam logic [3:0] ST_BIN    = 4'd9;
	localparam logic [3:0] ST_SUM    = 4'd10;
	localparam logic [3:0] ST_MED    = 4'd11;
	localparam logic [3:0] ST_DEV    = 4'd12;
	localparam logic [3:0] ST_DONE   = 4'd13;

	typedef struct packed {
		logic [3:0] mode;
		logic       start;
		logic       in_ready;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic       accepted;
		logic [1:0] op;
		logic       clr_done;
		logic       pass_done;
		logic       hit;
		logic       prune;
		logic       len_zero;
		logic       out_free;
	} stat_t;

endpackage

// ===== sv/rdh_in_if.sv =====
// ----------------------------------------------------------------------------
// rdh_in_if
// Request channel: operation, address and bin index.
// ----------------------------------------------------------------------------
interface rdh_in_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     op;
	logic [rdh_pkg::ADDR_W-1:0]     address;
	logic [rdh_pkg::BIN_W-1:0]      bin_index;

	modport source (output valid, output op, output address, output bin_index, input ready);
	modport sink   (input valid, input op, input address, input bin_index, output ready);
endinterface

// ===== sv/rdh_out_if.sv =====
// ----------------------------------------------------------------------------
// rdh_out_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
interface rdh_out_if;
	logic                       valid;
	logic                       ready;
	logic [rdh_pkg::BIN_W-1:0]  distance;
	logic                       first_use;
	logic [rdh_pkg::CNT_W-1:0]  bin_count;
	logic [rdh_pkg::CNT_W-1:0]  unique_count;
	logic [rdh_pkg::LEN_W-1:0]  used_length;
	logic [rdh_pkg::BIN_W-1:0]  med_dist;
	logic                       median_none;
	logic [rdh_pkg::BIN_W-1:0]  abs_deviation;

	modport source (output valid, output distance, output first_use, output bin_count,
		output unique_count, output used_length, output med_dist,
		output median_none, output abs_deviation, input ready);
	modport sink (input valid, input distance, input first_use, input bin_count,
		input unique_count, input used_length, input med_dist,
		input median_none, input abs_deviation, output ready);
endinterface

// ===== sv/reuse_distance_histogram.sv =====
// ----------------------------------------------------------------------------
// reuse_distance_histogram
// Reuse distance histogram over a bounded window of recent addresses.
// ----------------------------------------------------------------------------
// After reset the block clears its window and histogram memories before it
// takes the first request. Every request is handled alone, one at a time, by
// passes over scans of the two memories, one entry per cycle: an access scans
// the window on a miss, scans it again on a hit to count the distance, and
// scans it once more when the window has to be pruned; a bin read is a single
// histogram read; a median query makes a sum, a median and a deviation pass
// over the used length L, or none when L is zero. The next request is taken
// while a finished result still waits in the output register.
// ----------------------------------------------------------------------------
module reuse_distance_histogram #(
	parameter int MAX_WINDOW = rdh_pkg::MAX_WINDOW_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rdh_in_if.sink    req,
	rdh_out_if.source rsp
);

	rdh_pkg::cmd_t  cmd;
	rdh_pkg::stat_t st;

	rdh_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.st    (st),
		.cmd   (cmd)
	);

	rdh_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.st    (st),
		.req   (req),
		.rsp   (rsp)
	);

endmodule

// ===== sv/rdh_ram.sv =====
// ----------------------------------------------------------------------------
// rdh_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/rdh_datapath.sv =====
// ----------------------------------------------------------------------------
// rdh_datapath
// Window and histogram memories, scan counters, tallies and result register.
// ----------------------------------------------------------------------------
module rdh_datapath #(
	parameter int MAX_WINDOW = rdh_pkg::MAX_WINDOW_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rdh_pkg::cmd_t  cmd,
	output rdh_pkg::stat_t st,
	rdh_in_if.sink         req,
	rdh_out_if.source      rsp
);

	localparam int NS    = MAX_WINDOW + 1;
	localparam int CLR_N = (NS > rdh_pkg::NBINS) ? NS : rdh_pkg::NBINS;
	localparam int IW    = $clog2(CLR_N + 1);
	localparam int SAW   = $clog2(NS);
	localparam int SW    = 1 + rdh_pkg::ADDR_W + 64;
	localparam int BW    = rdh_pkg::BIN_W;
	localparam int LW    = rdh_pkg::LEN_W;
	localparam logic [IW-1:0] NS_I = IW'(NS);

	// control state
	logic [IW-1:0] idx_q;
	logic          ph_q;
	logic          rd_s1_q;
	logic          out_valid_q;
	logic [63:0]   now_q;
	logic [63:0]   unique_q;
	logic [LW-1:0] len_q;

	// payload
	logic [1:0]                 op_q;
	logic [rdh_pkg::ADDR_W-1:0] addr_q;
	logic [BW-1:0]              bin_q;
	logic                       hit_q;
	logic [SAW-1:0]             hit_idx_q;
	logic [63:0]                hit_stamp_q;
	logic                       free_found_q;
	logic [SAW-1:0]             free_idx_q;
	logic [IW-1:0]              live_q;
	logic [IW-1:0]              cnt_q;
	logic [63:0]                limit_q;
	logic [63:0]                sum_q;
	logic [63:0]                half_q;
	logic [63:0]                tally_q;
	logic [BW-1:0]              med_q;
	logic                       med_found_q;
	logic [BW-1:0]              mad_q;
	logic                       mad_found_q;
	logic [IW-1:0]              ridx_s1;
	logic                       ph_s1;
	logic                       incl_s1;

	logic [BW-1:0]              distance_q;
	logic                       first_use_q;
	logic [63:0]                bin_count_q;
	logic [63:0]                unique_count_q;
	logic [LW-1:0]              used_length_q;
	logic [BW-1:0]              median_q;
	logic                       median_none_q;
	logic [BW-1:0]              abs_dev_q;

	// memory ports
	logic           s_we, s_re, h_we, h_re;
	logic [SAW-1:0] s_waddr;
	logic [SW-1:0]  s_wdata, s_rdata;
	logic [BW-1:0]  h_waddr, h_raddr;
	logic [63:0]    h_wdata, h_rdata;

	logic           accept, is_pass, issue;
	logic [IW-1:0]  len_i, pass_n, live_after;
	logic [BW-1:0]  m_eff, mad_eff, lo_addr, dist_bin;
	logic [LW-1:0]  len_m1, hi_sum;
	logic           hi_incl, lo_incl;
	logic           s_valid;
	logic [63:0]    s_addr, s_stamp, med_sum, dev_sum, dev_part;
	logic [1:0]     mode_grp;

	assign accept    = req.valid & cmd.in_ready;
	assign req.ready = cmd.in_ready;

	assign len_i  = IW'(len_q);
	assign len_m1 = len_q - LW'(1);

	always_comb begin
		case (cmd.mode)
			rdh_pkg::ST_SCAN, rdh_pkg::ST_COUNT, rdh_pkg::ST_PRUNE: begin
				pass_n  = NS_I;
				is_pass = 1'b1;
			end
			rdh_pkg::ST_SUM, rdh_pkg::ST_MED, rdh_pkg::ST_DEV: begin
				pass_n  = len_i;
				is_pass = 1'b1;
			end
			default: begin
				pass_n  = len_i;
				is_pass = 1'b0;
			end
		endcase
	end

	assign issue = is_pass && (idx_q < pass_n);

	assign m_eff   = med_found_q ? med_q : len_m1[BW-1:0];
	assign mad_eff = mad_found_q ? mad_q : len_m1[BW-1:0];
	assign hi_sum  = {1'b0, m_eff} + {1'b0, idx_q[BW-1:0]};
	assign hi_incl = hi_sum < len_q;
	assign lo_addr = m_eff - idx_q[BW-1:0];
	assign lo_incl = (idx_q[BW-1:0] != '0) && (idx_q[BW-1:0] <= m_eff);

	assign s_valid = s_rdata[SW-1];
	assign s_addr  = s_rdata[SW-2 -: rdh_pkg::ADDR_W];
	assign s_stamp = s_rdata[63:0];

	assign dist_bin   = (cnt_q > IW'(255)) ? {BW{1'b1}} : cnt_q[BW-1:0];
	assign live_after = live_q + IW'(!hit_q && free_found_q);

	assign med_sum  = tally_q + h_rdata;
	assign dev_part = incl_s1 ? h_rdata : 64'd0;
	assign dev_sum  = tally_q + dev_part;

	// slot memory ports
	always_comb begin
		s_we    = 1'b0;
		s_waddr = idx_q[SAW-1:0];
		s_wdata = '0;
		case (cmd.mode)
			rdh_pkg::ST_CLEAR: begin
				s_we = idx_q < NS_I;
			end
			rdh_pkg::ST_SLOT: begin
				s_we    = 1'b1;
				s_waddr = hit_q ? hit_idx_q : (free_found_q ? free_idx_q : '0);
				s_wdata = {1'b1, addr_q, now_q};
			end
			rdh_pkg::ST_PRUNE: begin
				// drop entries older than the limit
				s_we    = rd_s1_q && s_valid && (s_stamp < limit_q);
				s_waddr = ridx_s1[SAW-1:0];
				s_wdata = {1'b0, s_addr, s_stamp};
			end
			default: ;
		endcase
	end

	assign s_re = issue && ((cmd.mode == rdh_pkg::ST_SCAN) ||
		(cmd.mode == rdh_pkg::ST_COUNT) || (cmd.mode == rdh_pkg::ST_PRUNE));

	// histogram memory ports
	always_comb begin
		h_we    = 1'b0;
		h_waddr = idx_q[BW-1:0];
		h_wdata = '0;
		h_re    = 1'b0;
		h_raddr = idx_q[BW-1:0];
		case (cmd.mode)
			rdh_pkg::ST_CLEAR: begin
				h_we = idx_q < IW'(rdh_pkg::NBINS);
			end
			rdh_pkg::ST_HIST: begin
				h_re    = hit_q;
				h_raddr = dist_bin;
			end
			rdh_pkg::ST_HWRITE: begin
				h_we    = 1'b1;
				h_waddr = dist_bin;
				h_wdata = h_rdata + 64'd1;
			end
			rdh_pkg::ST_BIN: begin
				h_re    = 1'b1;
				h_raddr = bin_q;
			end
			rdh_pkg::ST_SUM, rdh_pkg::ST_MED: begin
				h_re = issue;
			end
			rdh_pkg::ST_DEV: begin
				h_re    = issue;
				h_raddr = ph_q ? lo_addr : hi_sum[BW-1:0];
			end
			default: ;
		endcase
	end

	rdh_ram #(.WIDTH(SW), .DEPTH(NS)) u_slot_ram (
		.clk    (clk),
		.wr_en  (s_we),
		.wr_addr(s_waddr),
		.wr_data(s_wdata),
		.rd_en  (s_re),
		.rd_addr(idx_q[SAW-1:0]),
		.rd_data(s_rdata)
	);

	rdh_ram #(.WIDTH(64), .DEPTH(rdh_pkg::NBINS)) u_hist_ram (
		.clk    (clk),
		.wr_en  (h_we),
		.wr_addr(h_waddr),
		.wr_data(h_wdata),
		.rd_en  (h_re),
		.rd_addr(h_raddr),
		.rd_data(h_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			ph_q        <= 1'b0;
			rd_s1_q     <= 1'b0;
			out_valid_q <= 1'b0;
			now_q       <= '0;
			unique_q    <= '0;
			len_q       <= '0;
		end else begin
			if (cmd.start) begin
				idx_q   <= '0;
				ph_q    <= 1'b0;
				rd_s1_q <= 1'b0;
			end else if (cmd.mode == rdh_pkg::ST_CLEAR) begin
				idx_q <= idx_q + IW'(1);
			end else begin
				rd_s1_q <= issue;
				if (issue) begin
					if (cmd.mode == rdh_pkg::ST_DEV) begin
						ph_q <= ~ph_q;
						if (ph_q)
							idx_q <= idx_q + IW'(1);
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
			end

			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;

			if (cmd.mode == rdh_pkg::ST_SLOT)
				now_q <= now_q + 64'd1;
			if ((cmd.mode == rdh_pkg::ST_HIST) && !hit_q)
				unique_q <= unique_q + 64'd1;
			if ((cmd.mode == rdh_pkg::ST_HWRITE) && ({1'b0, dist_bin} >= len_q))
				len_q <= {1'b0, dist_bin} + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= idx_q;
		ph_s1   <= ph_q;
		incl_s1 <= ph_q ? lo_incl : hi_incl;

		if (rd_s1_q) begin
			case (cmd.mode)
				rdh_pkg::ST_SCAN: begin
					if (s_valid) begin
						live_q <= live_q + IW'(1);
						if (s_addr == addr_q) begin
							hit_q       <= 1'b1;
							hit_idx_q   <= ridx_s1[SAW-1:0];
							hit_stamp_q <= s_stamp;
						end
					end else if (!free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= ridx_s1[SAW-1:0];
					end
				end
				rdh_pkg::ST_COUNT: begin
					if (s_valid && (ridx_s1[SAW-1:0] != hit_idx_q) &&
						(s_stamp > hit_stamp_q))
						cnt_q <= cnt_q + IW'(1);
				end
				rdh_pkg::ST_SUM: begin
					sum_q <= sum_q + h_rdata;
				end
				rdh_pkg::ST_MED: begin
					if (!med_found_q) begin
						tally_q <= med_sum;
						if (med_sum > half_q) begin
							med_q       <= ridx_s1[BW-1:0];
							med_found_q <= 1'b1;
						end
					end
				end
				rdh_pkg::ST_DEV: begin
					// upper neighbour first, lower neighbour closes the bin
					if (!mad_found_q) begin
						tally_q <= dev_sum;
						if (ph_s1 && (dev_sum > half_q)) begin
							mad_q       <= ridx_s1[BW-1:0];
							mad_found_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end

		if (cmd.mode == rdh_pkg::ST_SUM)
			half_q <= (unique_q - 64'(len_q) + sum_q) >> 1;
		if (cmd.mode == rdh_pkg::ST_SLOT)
			limit_q <= now_q + 64'd1 - 64'(MAX_WINDOW);
		if (cmd.start)
			tally_q <= '0;

		if (accept) begin
			op_q         <= req.op;
			addr_q       <= req.address;
			bin_q        <= req.bin_index;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			live_q       <= '0;
			cnt_q        <= '0;
			sum_q        <= '0;
			med_found_q  <= 1'b0;
			mad_found_q  <= 1'b0;
		end

		if (cmd.load_out) begin
			distance_q     <= ((op_q == rdh_pkg::OP_ACCESS) && hit_q) ? dist_bin : '0;
			first_use_q    <= (op_q == rdh_pkg::OP_ACCESS) && !hit_q;
			bin_count_q    <= ((op_q == rdh_pkg::OP_BIN) && ({1'b0, bin_q} < len_q)) ?
				h_rdata : 64'd0;
			unique_count_q <= unique_q;
			used_length_q  <= len_q;
			median_none_q  <= (op_q == rdh_pkg::OP_MEDIAN) && (len_q == '0);
			median_q       <= ((op_q == rdh_pkg::OP_MEDIAN) && (len_q != '0)) ? m_eff : '0;
			abs_dev_q      <= ((op_q == rdh_pkg::OP_MEDIAN) && (len_q != '0)) ? mad_eff : '0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.distance      = distance_q;
	assign rsp.first_use     = first_use_q;
	assign rsp.bin_count     = bin_count_q;
	assign rsp.unique_count  = unique_count_q;
	assign rsp.used_length   = used_length_q;
	assign rsp.med_dist      = median_q;
	assign rsp.median_none   = median_none_q;
	assign rsp.abs_deviation = abs_dev_q;

	assign mode_grp = op_q;

	always_comb begin
		st.accepted  = accept;
		st.op        = mode_grp;
		st.clr_done  = idx_q == IW'(CLR_N - 1);
		st.pass_done = (idx_q >= pass_n) && !rd_s1_q;
		st.hit       = hit_q;
		st.prune     = live_after > IW'(MAX_WINDOW);
		st.len_zero  = len_q == '0;
		st.out_free  = !out_valid_q || rsp.ready;
	end

endmodule

// ===== sv/rdh_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdh_ctrl
// Sequencer: steps each request through its scan and histogram passes.
// ----------------------------------------------------------------------------
module rdh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  rdh_pkg::stat_t st,
	output rdh_pkg::cmd_t  cmd
);

	logic [3:0] state_q, state_d;
	logic       start;

	always_comb begin
		state_d = state_q;
		start   = 1'b0;
		case (state_q)
			rdh_pkg::ST_CLEAR: begin
				if (st.clr_done)
					state_d = rdh_pkg::ST_IDLE;
			end
			rdh_pkg::ST_IDLE: begin
				if (st.accepted)
					state_d = rdh_pkg::ST_DISP;
			end
			rdh_pkg::ST_DISP: begin
				case (st.op)
					rdh_pkg::OP_ACCESS: begin
						state_d = rdh_pkg::ST_SCAN;
						start   = 1'b1;
					end
					rdh_pkg::OP_BIN: state_d = rdh_pkg::ST_BIN;
					rdh_pkg::OP_MEDIAN: begin
						if (st.len_zero) begin
							state_d = rdh_pkg::ST_DONE;
						end else begin
							state_d = rdh_pkg::ST_SUM;
							start   = 1'b1;
						end
					end
					default: state_d = rdh_pkg::ST_DONE;
				endcase
			end
			rdh_pkg::ST_SCAN: begin
				if (st.pass_done) begin
					if (st.hit) begin
						state_d = rdh_pkg::ST_COUNT;
						start   = 1'b1;
					end else begin
						state_d = rdh_pkg::ST_HIST;
					end
				end
			end
			rdh_pkg::ST_COUNT: begin
				if (st.pass_done)
					state_d = rdh_pkg::ST_HIST;
			end
			rdh_pkg::ST_HIST: begin
				state_d = st.hit ? rdh_pkg::ST_HWRITE : rdh_pkg::ST_SLOT;
			end
			rdh_pkg::ST_HWRITE: state_d = rdh_pkg::ST_SLOT;
			rdh_pkg::ST_SLOT: begin
				if (st.prune) begin
					state_d = rdh_pkg::ST_PRUNE;
					start   = 1'b1;
				end else begin
					state_d = rdh_pkg::ST_DONE;
				end
			end
			rdh_pkg::ST_PRUNE: begin
				if (st.pass_done)
					state_d = rdh_pkg::ST_DONE;
			end
			rdh_pkg::ST_BIN: state_d = rdh_pkg::ST_DONE;
			rdh_pkg::ST_SUM: begin
				if (st.pass_done) begin
					state_d = rdh_pkg::ST_MED;
					start   = 1'b1;
				end
			end
			rdh_pkg::ST_MED: begin
				if (st.pass_done) begin
					state_d = rdh_pkg::ST_DEV;
					start   = 1'b1;
				end
			end
			rdh_pkg::ST_DEV: begin
				if (st.pass_done)
					state_d = rdh_pkg::ST_DONE;
			end
			rdh_pkg::ST_DONE: begin
				// hold until the result register is free
				if (st.out_free)
					state_d = rdh_pkg::ST_IDLE;
			end
			default: state_d = rdh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rdh_pkg::ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		cmd.mode     = state_q;
		cmd.start    = start;
		cmd.in_ready = state_q == rdh_pkg::ST_IDLE;
		cmd.load_out = (state_q == rdh_pkg::ST_DONE) && st.out_free;
	end

endmodule

// ===== sim/tb_reuse_distance_histogram.sv =====
// ----------------------------------------------------------------------------
// tb_reuse_distance_histogram
// Self-checking testbench for the reuse distance histogram block.
// ----------------------------------------------------------------------------
// A driver feeds requests from a queue. A monitor mirrors the window and the
// histogram to predict each result, then checks every result field by field.
// Directed requests come first, then random traffic. The random traffic is
// built from small address pools, fresh addresses, bin reads, median queries,
// unused operations and long sweeps that force the window to be pruned.
// ----------------------------------------------------------------------------
module tb_reuse_distance_histogram;

	localparam int WIN       = rdh_pkg::MAX_WINDOW_DEF;
	localparam int NSLOT     = WIN + 1;
	localparam int WDOG_MAX  = 40000;
	localparam int N_ITEMS   = 1850;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct {
		logic [1:0]                 op;
		logic [rdh_pkg::ADDR_W-1:0] address;
		logic [rdh_pkg::BIN_W-1:0]  bin_index;
	} request_t;

	typedef struct {
		logic [rdh_pkg::BIN_W-1:0] distance;
		logic                      first_use;
		logic [rdh_pkg::CNT_W-1:0] bin_count;
		logic [rdh_pkg::CNT_W-1:0] unique_count;
		logic [rdh_pkg::LEN_W-1:0] used_length;
		logic [rdh_pkg::BIN_W-1:0] med_dist;
		logic                      median_none;
		logic [rdh_pkg::BIN_W-1:0] abs_deviation;
	} response_t;

	logic clk;
	logic arst_n;

	rdh_in_if  req_if();
	rdh_out_if rsp_if();

	reuse_distance_histogram #(.MAX_WINDOW(WIN)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// shadow copy of the block state
	logic [rdh_pkg::ADDR_W-1:0] win_addr  [NSLOT];
	logic [63:0]                win_stamp [NSLOT];
	logic                       win_live  [NSLOT];
	logic [63:0]                clock_now;
	logic [rdh_pkg::CNT_W-1:0]  hist_bin  [rdh_pkg::NBINS];
	logic [rdh_pkg::CNT_W-1:0]  unique_tally;
	int unsigned                bins_used;

	request_t  pending_reqs[$];
	response_t expected_rsps[$];
	int        n_fail;
	int        n_accepted;
	int        idle_cycles;
	int        src_idle_pct;
	int        snk_idle_pct;
	bit        hold_req;
	bit        req_fire;

	function automatic response_t predict_response(request_t rq);
		response_t r;
		int hit, freeslot, live, cnt, m, k;
		logic [63:0] total, half, tally, limit;
		logic [rdh_pkg::CNT_W-1:0] devs[rdh_pkg::NBINS];
		r = '{default: '0};
		if (rq.op == rdh_pkg::OP_ACCESS) begin
			hit = -1;
			freeslot = -1;
			for (int i = 0; i < NSLOT; i++) begin
				if (win_live[i]) begin
					if (win_addr[i] == rq.address)
						hit = i;
				end else if (freeslot < 0) begin
					freeslot = i;
				end
			end
			if (hit >= 0) begin
				cnt = 0;
				for (int i = 0; i < NSLOT; i++)
					if (win_live[i] && i != hit && win_stamp[i] > win_stamp[hit])
						cnt++;
				if (cnt > rdh_pkg::NBINS - 1)
					cnt = rdh_pkg::NBINS - 1;
				if (cnt >= bins_used)
					bins_used = cnt + 1;
				hist_bin[cnt] = hist_bin[cnt] + 1;
				r.distance = cnt[rdh_pkg::BIN_W-1:0];
			end else begin
				unique_tally = unique_tally + 1;
				r.first_use = 1'b1;
				hit = (freeslot >= 0) ? freeslot : 0;
			end
			win_live[hit]  = 1'b1;
			win_addr[hit]  = rq.address;
			win_stamp[hit] = clock_now;
			clock_now = clock_now + 1;
			live = 0;
			for (int i = 0; i < NSLOT; i++)
				if (win_live[i])
					live++;
			if (live > WIN) begin
				limit = clock_now - 64'(WIN);
				for (int i = 0; i < NSLOT; i++)
					if (win_live[i] && win_stamp[i] < limit)
						win_live[i] = 1'b0;
			end
		end else if (rq.op == rdh_pkg::OP_BIN) begin
			if (rq.bin_index < bins_used)
				r.bin_count = hist_bin[rq.bin_index];
		end else if (rq.op == rdh_pkg::OP_MEDIAN) begin
			if (bins_used == 0) begin
				r.median_none = 1'b1;
			end else begin
				total = unique_tally - 64'(bins_used);
				for (int d = 0; d < bins_used; d++)
					total = total + hist_bin[d];
				half = total / 2;
				tally = 0;
				m = 0;
				for (int d = 0; d < bins_used; d++) begin
					m = d;
					tally = tally + hist_bin[d];
					if (tally > half)
						break;
				end
				for (int d = 0; d < rdh_pkg::NBINS; d++)
					devs[d] = '0;
				for (int d = 0; d < bins_used; d++) begin
					k = (d > m) ? d - m : m - d;
					devs[k % rdh_pkg::NBINS] = devs[k % rdh_pkg::NBINS] + hist_bin[d];
				end
				tally = 0;
				for (int d = 0; d < bins_used; d++) begin
					r.abs_deviation = d[rdh_pkg::BIN_W-1:0];
					tally = tally + devs[d];
					if (tally > half)
						break;
				end
				r.med_dist = m[rdh_pkg::BIN_W-1:0];
			end
		end
		r.unique_count = unique_tally;
		r.used_length  = bins_used[rdh_pkg::LEN_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_fail++;
		end
	endtask

	// monitor: predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		response_t w;
		request_t  rq;
		req_fire <= arst_n && req_if.valid && req_if.ready;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				rq.op        = req_if.op;
				rq.address   = req_if.address;
				rq.bin_index = req_if.bin_index;
				expected_rsps.push_back(predict_response(rq));
				n_accepted++;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("result with no request outstanding");
					n_fail++;
				end else begin
					w = expected_rsps.pop_front();
					check_field("distance", w.distance, rsp_if.distance);
					check_field("first_use", w.first_use, rsp_if.first_use);
					check_field("bin_count", w.bin_count, rsp_if.bin_count);
					check_field("unique_count", w.unique_count, rsp_if.unique_count);
					check_field("used_length", w.used_length, rsp_if.used_length);
					check_field("med_dist", w.med_dist, rsp_if.med_dist);
					check_field("median_none", w.median_none, rsp_if.median_none);
					check_field("abs_deviation", w.abs_deviation, rsp_if.abs_deviation);
				end
			end
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WDOG_MAX) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// driver: advance to the next request only once the current one is taken
	always @(negedge clk) begin
		request_t rq;
		if (n_accepted < 620) begin
			src_idle_pct = 27;
			snk_idle_pct = 56;
		end else if (n_accepted < 1240) begin
			src_idle_pct = 56;
			snk_idle_pct = 27;
		end else begin
			src_idle_pct = 0;
			snk_idle_pct = 0;
		end
		// drain everything at two points mid-run before sending more
		if (n_accepted == 400 || n_accepted == 1240)
			hold_req = 1'b1;
		if (hold_req && expected_rsps.size() == 0)
			hold_req = 1'b0;
		if (arst_n) begin
			rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			if (!req_if.valid || req_fire) begin
				if (pending_reqs.size() != 0 && !hold_req
						&& $urandom_range(99) >= src_idle_pct) begin
					rq = pending_reqs.pop_front();
					req_if.valid     <= 1'b1;
					req_if.op        <= rq.op;
					req_if.address   <= rq.address;
					req_if.bin_index <= rq.bin_index;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic push_req(logic [1:0] op, logic [63:0] a, logic [7:0] b);
		request_t rq;
		rq.op        = op;
		rq.address   = a;
		rq.bin_index = b;
		pending_reqs.push_back(rq);
	endtask

	logic [63:0] addr_pool[32];

	initial begin
		int n, r, span;
		logic [63:0] base;
		req_if.valid     = 1'b0;
		req_if.op        = rdh_pkg::OP_ACCESS;
		req_if.address   = '0;
		req_if.bin_index = '0;
		rsp_if.ready     = 1'b0;
		n_fail       = 0;
		n_accepted   = 0;
		idle_cycles  = 0;
		hold_req     = 1'b0;
		req_fire     = 1'b0;
		clock_now    = '0;
		unique_tally = '0;
		bins_used    = 0;
		for (int i = 0; i < NSLOT; i++) begin
			win_live[i]  = 1'b0;
			win_addr[i]  = '0;
			win_stamp[i] = '0;
		end
		for (int i = 0; i < rdh_pkg::NBINS; i++)
			hist_bin[i] = '0;

		// directed: empty histogram, extremes, every op
		push_req(rdh_pkg::OP_MEDIAN, '0, '0);
		push_req(rdh_pkg::OP_BIN, '0, 8'd0);
		push_req(rdh_pkg::OP_ACCESS, 64'd0, '0);
		push_req(rdh_pkg::OP_ACCESS, '1, '1);
		push_req(rdh_pkg::OP_ACCESS, 64'd0, '0);
		push_req(rdh_pkg::OP_ACCESS, '1, '0);
		push_req(rdh_pkg::OP_ACCESS, 64'haaaa_aaaa_aaaa_aaaa, 8'haa);
		push_req(rdh_pkg::OP_ACCESS, 64'h5555_5555_5555_5555, 8'h55);
		push_req(rdh_pkg::OP_ACCESS, 64'd0, '0);
		push_req(rdh_pkg::OP_BIN, '0, 8'd0);
		push_req(rdh_pkg::OP_BIN, '0, 8'd1);
		push_req(rdh_pkg::OP_BIN, '0, 8'd3);
		push_req(rdh_pkg::OP_BIN, '1, 8'd255);
		push_req(rdh_pkg::OP_BIN, '0, 8'haa);
		push_req(rdh_pkg::OP_BIN, '0, 8'h55);
		push_req(rdh_pkg::OP_MEDIAN, '1, '1);
		push_req(OP_SPARE, 64'h1234_5678_9abc_def0, 8'h5a);
		push_req(OP_SPARE, '1, '1);
		push_req(rdh_pkg::OP_MEDIAN, '0, '0);

		for (int i = 0; i < 32; i++)
			addr_pool[i] = rand64();
		n = pending_reqs.size();
		while (n < N_ITEMS) begin
			r = $urandom_range(99);
			if (r < 2 && n < N_ITEMS - 600) begin
				// sweep between WIN-10 and WIN+20 fresh addresses, twice over
				base = rand64();
				span = $urandom_range(WIN + 20, WIN - 10);
				for (int p = 0; p < 2; p++)
					for (int i = 0; i < span; i++)
						push_req(rdh_pkg::OP_ACCESS, base + 64'(i), 8'($urandom));
				push_req(rdh_pkg::OP_MEDIAN, rand64(), 8'($urandom));
				push_req(rdh_pkg::OP_BIN, rand64(), 8'($urandom_range(255, 240)));
				n += 2 * span + 2;
			end else begin
				if (r < 55)
					push_req(rdh_pkg::OP_ACCESS,
						addr_pool[$urandom_range($urandom_range(1) ? 7 : 31)],
						8'($urandom));
				else if (r < 62)
					push_req(rdh_pkg::OP_ACCESS, rand64(), 8'($urandom));
				else if (r < 76)
					push_req(rdh_pkg::OP_BIN, rand64(),
						$urandom_range(1) ? 8'($urandom_range(33)) : 8'($urandom));
				else if (r < 90)
					push_req(rdh_pkg::OP_MEDIAN, rand64(), 8'($urandom));
				else if (r < 94)
					push_req(OP_SPARE, rand64(), 8'($urandom));
				else
					addr_pool[$urandom_range(31)] = rand64();
				if (r < 94)
					n++;
			end
		end

		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_reqs.size() == 0);
		@(posedge clk);
		while (req_if.valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (2000) @(posedge clk);
		if (n_fail == 0 && expected_rsps.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== reuse_distance_histogram.f =====
sv/rdh_pkg.sv
sv/rdh_in_if.sv
sv/rdh_out_if.sv
sv/rdh_ram.sv
sv/rdh_datapath.sv
sv/rdh_ctrl.sv
sv/reuse_distance_histogram.sv
sim/tb_reuse_distance_histogram.sv
